FILE: sv/capture_period_to_decimal_frequency_assert.svh
// Assertion macros shared by the capture period to frequency block.
`ifndef CAPTURE_PERIOD_TO_DECIMAL_FREQUENCY_ASSERT_SVH
`define CAPTURE_PERIOD_TO_DECIMAL_FREQUENCY_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define CPDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cpdf assertion failed");
// Implication checked in the same cycle outside reset.
`define CPDF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cpdf implication failed");
`else
`define CPDF_ASSERT(lbl, clk, rstn, prop)
`define CPDF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/cpdf_pkg.sv
// Package with the widths, constants and result type of the frequency meter.
`timescale 1ns / 1ps
package cpdf_pkg;

  // Width of the timestamps and of the period.
  localparam int unsigned TimeBits = 16;
  // Width of the numerator register and of the integer part.
  localparam int unsigned NumBits = 16;
  // Width of one decimal digit.
  localparam int unsigned DigitBits = 4;
  // Width of the scaled remainder: a value below ten times the period.
  localparam int unsigned ScaledBits = TimeBits + 4;
  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  // Numerator after reset.
  localparam logic [NumBits-1:0] NumeratorReset = NumBits'(1000);
  // Highest value of a decimal digit.
  localparam logic [DigitBits-1:0] DigitMax = DigitBits'(9);

  typedef logic [TimeBits-1:0] time_t;

  // One result item.
  typedef struct packed {
    logic [TimeBits-1:0]  period;
    logic [NumBits-1:0]   int_part;
    logic [DigitBits-1:0] tenths;
    logic [DigitBits-1:0] hundredths;
    logic [DigitBits-1:0] thousandths;
    logic                 zero_period;
  } res_t;

endpackage

FILE: sv/cpdf_front.sv
// Capture front end: keeps the last timestamp and pair parity, forms periods.
`timescale 1ns / 1ps
module cpdf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cpdf_pkg::time_t      capture_time_i,
  output logic                 full_o,
  output logic                 job_push_o,
  output cpdf_pkg::time_t      job_period_o,
  input  logic                 job_full_i
);

  cpdf_pkg::time_t last_q, last_d;
  logic            parity_q, parity_d;
  logic            accept;

  // Items are held off only while the queue to the divider is full.
  assign full_o = job_full_i;
  assign accept = push_i & ~job_full_i;

  // The period wraps naturally at the timestamp width.
  assign job_period_o = capture_time_i - last_q;
  assign job_push_o   = accept & parity_q;

  // The first capture of a pair is stored; the second sends a job and restarts at zero.
  always_comb begin
    last_d   = last_q;
    parity_d = parity_q;
    if (accept) begin
      if (parity_q) begin
        last_d   = '0;
        parity_d = 1'b0;
      end else begin
        last_d   = capture_time_i;
        parity_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      parity_q <= 1'b0;
    end else begin
      last_q   <= last_d;
      parity_q <= parity_d;
    end
  end

endmodule

FILE: sv/cpdf_queue.sv
// Short queue of periods between the capture front end and the divider.
`timescale 1ns / 1ps
module cpdf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cpdf_pkg::time_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output cpdf_pkg::time_t data_o,
  output logic            empty_o
);

  cpdf_pkg::time_t                       slots_q [cpdf_pkg::QueueDepth];
  logic [cpdf_pkg::QueuePtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [cpdf_pkg::QueuePtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [cpdf_pkg::QueueCntBits-1:0]     count_q, count_d;
  logic                                  do_push;
  logic                                  do_pop;

  assign full_o  = (count_q == cpdf_pkg::QueueCntBits'(cpdf_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cpdf_pkg::QueuePtrBits'(cpdf_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cpdf_pkg::QueuePtrBits'(cpdf_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/cpdf_back.sv
// Divider back end: sequential long division into integer part and three digits.
`timescale 1ns / 1ps
`include "capture_period_to_decimal_frequency_assert.svh"
module cpdf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          numerator_we_i,
  input  logic [cpdf_pkg::NumBits-1:0]  numerator_i,
  input  logic                          job_empty_i,
  input  cpdf_pkg::time_t               job_period_i,
  output logic                          job_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output cpdf_pkg::res_t                res_o
);

  localparam int unsigned TB = cpdf_pkg::TimeBits;
  localparam int unsigned SB = cpdf_pkg::ScaledBits;
  localparam int unsigned DB = cpdf_pkg::DigitBits;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInt   = 3'd1;
  localparam logic [2:0] StScale = 3'd2;
  localparam logic [2:0] StDigit = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  localparam logic [1:0] DigTenths      = 2'd0;
  localparam logic [1:0] DigHundredths  = 2'd1;
  localparam logic [1:0] DigThousandths = 2'd2;

  logic [2:0]                      state_q, state_d;
  logic [cpdf_pkg::NumBits-1:0]    numer_q, numer_d;
  cpdf_pkg::time_t                 period_q, period_d;
  logic [SB-1:0]                   work_q, work_d;
  logic [cpdf_pkg::NumBits-1:0]    num_sh_q, num_sh_d;
  logic [cpdf_pkg::NumBits-1:0]    quot_q, quot_d;
  logic [3:0]                      cnt_q, cnt_d;
  logic [1:0]                      dig_idx_q, dig_idx_d;
  logic [DB-1:0]                   dig_q, dig_d;
  logic [DB-1:0]                   tenths_q, tenths_d;
  logic [DB-1:0]                   hund_q, hund_d;
  logic [DB-1:0]                   thou_q, thou_d;
  logic                            zero_q, zero_d;
  logic                            out_valid_q, out_valid_d;
  cpdf_pkg::res_t                  res_q, res_d;

  logic [TB:0]                     int_trial;
  logic                            int_ge;
  logic [TB:0]                     int_diff;
  logic [SB-1:0]                   dig_div;
  logic                            dig_ge;
  logic [SB-1:0]                   scaled;
  logic [DB-1:0]                   dig_final;
  logic                            out_free;

  // One restoring step of the integer quotient.
  assign int_trial = {work_q[TB-1:0], num_sh_q[cpdf_pkg::NumBits-1]};
  assign int_ge    = (int_trial >= {1'b0, period_q});
  assign int_diff  = int_trial - {1'b0, period_q};

  // One digit step compares against the period shifted by the bit weight.
  assign dig_div   = {{(SB-TB){1'b0}}, period_q} << cnt_q[1:0];
  assign dig_ge    = (work_q >= dig_div);
  assign dig_final = {dig_q[DB-2:0], dig_ge};

  // Remainder times ten as two shifted adds.
  assign scaled = ({{(SB-TB){1'b0}}, work_q[TB-1:0]} << 3)
                + ({{(SB-TB){1'b0}}, work_q[TB-1:0]} << 1);

  assign out_free  = ~out_valid_q | pop_i;
  assign job_pop_o = (state_q == StIdle) & ~job_empty_i;
  assign empty_o   = ~out_valid_q;
  assign res_o     = res_q;

  // Division sequencer.
  always_comb begin
    state_d     = state_q;
    numer_d     = numer_q;
    period_d    = period_q;
    work_d      = work_q;
    num_sh_d    = num_sh_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    dig_idx_d   = dig_idx_q;
    dig_d       = dig_q;
    tenths_d    = tenths_q;
    hund_d      = hund_q;
    thou_d      = thou_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q & ~pop_i;
    res_d       = res_q;

    if (numerator_we_i) begin
      numer_d = numerator_i;
    end

    unique case (state_q)
      StIdle: begin
        if (!job_empty_i) begin
          period_d  = job_period_i;
          num_sh_d  = numer_q;
          work_d    = '0;
          quot_d    = '0;
          cnt_d     = 4'(cpdf_pkg::NumBits - 1);
          dig_idx_d = DigTenths;
          tenths_d  = '0;
          hund_d    = '0;
          thou_d    = '0;
          zero_d    = (job_period_i == '0);
          state_d   = (job_period_i == '0) ? StDone : StInt;
        end
      end
      StInt: begin
        work_d   = int_ge ? {{(SB-TB){1'b0}}, int_diff[TB-1:0]}
                          : {{(SB-TB){1'b0}}, int_trial[TB-1:0]};
        quot_d   = {quot_q[cpdf_pkg::NumBits-2:0], int_ge};
        num_sh_d = num_sh_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StScale;
        end
      end
      StScale: begin
        work_d  = scaled;
        cnt_d   = 4'(DB - 1);
        dig_d   = '0;
        state_d = StDigit;
      end
      StDigit: begin
        if (dig_ge) begin
          work_d = work_q - dig_div;
        end
        dig_d = dig_final;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          case (dig_idx_q)
            DigTenths:     tenths_d = dig_final;
            DigHundredths: hund_d   = dig_final;
            default:       thou_d   = dig_final;
          endcase
          if (dig_idx_q == DigThousandths) begin
            state_d = StDone;
          end else begin
            dig_idx_d = dig_idx_q + 1'b1;
            state_d   = StScale;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          res_d.period      = period_q;
          res_d.int_part    = zero_q ? '0 : quot_q;
          res_d.tenths      = tenths_q;
          res_d.hundredths  = hund_q;
          res_d.thousandths = thou_q;
          res_d.zero_period = zero_q;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      numer_q     <= cpdf_pkg::NumeratorReset;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dig_idx_q   <= DigTenths;
    end else begin
      state_q     <= state_d;
      numer_q     <= numer_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dig_idx_q   <= dig_idx_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    work_q   <= work_d;
    num_sh_q <= num_sh_d;
    quot_q   <= quot_d;
    dig_q    <= dig_d;
    tenths_q <= tenths_d;
    hund_q   <= hund_d;
    thou_q   <= thou_d;
    zero_q   <= zero_d;
    res_q    <= res_d;
  end

  // The partial remainder stays below the period throughout the integer steps.
  `CPDF_ASSERT_IMP(a_rem_below_period, clk_i, rst_ni, state_q == StInt, work_q < SB'(period_q))
  // Only three digits are ever worked on.
  `CPDF_ASSERT_IMP(a_digit_index, clk_i, rst_ni, state_q == StDigit, dig_idx_q != 2'd3)
  // A waiting result holds decimal digits only.
  `CPDF_ASSERT_IMP(a_tenths_ok, clk_i, rst_ni, out_valid_q, res_q.tenths <= cpdf_pkg::DigitMax)
  `CPDF_ASSERT_IMP(a_hund_ok, clk_i, rst_ni, out_valid_q, res_q.hundredths <= cpdf_pkg::DigitMax)
  `CPDF_ASSERT_IMP(a_thou_ok, clk_i, rst_ni, out_valid_q, res_q.thousandths <= cpdf_pkg::DigitMax)
  // A zero period gives a zero period field and all digits cleared.
  `CPDF_ASSERT_IMP(a_zero_result, clk_i, rst_ni, out_valid_q && res_q.zero_period, (res_q >> 1) == '0)

endmodule

FILE: sv/capture_period_to_decimal_frequency.sv
// Top level of the capture period to decimal frequency meter.
//
//   Channel   Handshake            Payload
//   capture   push / full          capture_time_i
//   result    empty / pop          period_o, int_part_o, tenths_o, hundredths_o,
//                                  thousandths_o, zero_period_o
//   config    numerator_we_i       numerator_i
//
// The front end takes one capture per cycle while the two-entry period queue has room.
// The divider works a pair as a load, the quotient steps of the 16-bit integer part, a
// scale step and the digit steps for each of three digits, and a fill of the result
// register; a zero period goes from the load straight to the result.
// Reset clears the stored timestamp, the pair parity and the queue, and loads 1000 as
// the numerator. A waiting result stalls only the divider; captures still enter the queue.
`timescale 1ns / 1ps
module capture_period_to_decimal_frequency (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] capture_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] period_o,
  output logic [15:0] int_part_o,
  output logic [3:0]  tenths_o,
  output logic [3:0]  hundredths_o,
  output logic [3:0]  thousandths_o,
  output logic        zero_period_o,
  input  logic        numerator_we_i,
  input  logic [15:0] numerator_i
);

  logic            job_push;
  logic            job_full;
  cpdf_pkg::time_t job_period_in;
  cpdf_pkg::time_t job_period_out;
  logic            job_empty;
  logic            job_pop;
  cpdf_pkg::res_t  res;

  cpdf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .capture_time_i (capture_time_i),
    .full_o         (full),
    .job_push_o     (job_push),
    .job_period_o   (job_period_in),
    .job_full_i     (job_full)
  );

  cpdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_period_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_period_out),
    .empty_o (job_empty)
  );

  cpdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .numerator_we_i (numerator_we_i),
    .numerator_i    (numerator_i),
    .job_empty_i    (job_empty),
    .job_period_i   (job_period_out),
    .job_pop_o      (job_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .res_o          (res)
  );

  // Result fields straight from the output register.
  assign period_o      = res.period;
  assign int_part_o    = res.int_part;
  assign tenths_o      = res.tenths;
  assign hundredths_o  = res.hundredths;
  assign thousandths_o = res.thousandths;
  assign zero_period_o = res.zero_period;

endmodule
